@@ design/ohs_pkg.sv @@
// Package for the open-addressing hash set: sizes, codes and the
// command/status structs between controller and datapath. No dependencies.
package ohs_pkg;

  localparam int CAPACITY  = 1024;  // slots, power of two
  localparam int KEY_WIDTH = 32;    // compared key bits

  localparam int SLOT_W  = $clog2(CAPACITY);
  localparam int CNT_W   = SLOT_W + 1;
  localparam int LOAD_W  = CNT_W + 2;
  localparam int STORE_W = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_ADD    = 2'd0;
  localparam cmd_t CMD_REMOVE = 2'd1;
  localparam cmd_t CMD_QUERY  = 2'd2;
  localparam cmd_t CMD_CLEAR  = 2'd3;

  typedef logic [1:0] mark_t;
  localparam mark_t MARK_EMPTY    = 2'd0;
  localparam mark_t MARK_OCCUPIED = 2'd1;
  localparam mark_t MARK_DELETED  = 2'd2;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_PROBE
  } state_t;

  typedef struct packed {
    logic load;       // latch request, start probe at its hash
    logic advance;    // step to next probe slot
    logic fin_probe;  // commit probe result and load output word
    logic clr_start;  // zero counts, restart sweep
    logic sweep;      // write one empty mark
    logic fin_clear;  // load output word of a clear
  } dp_cmd_t;

  typedef struct packed {
    logic req_clear;  // pending request is a clear
    logic probe_end;  // current slot ends the probe
    logic sweep_done; // sweep is on its last slot
  } dp_sts_t;

endpackage

@@ design/ohs_if.sv @@
// Request and response channel interfaces of the hash set.
// Depends on ohs_pkg.
interface ohs_req_if;
  import ohs_pkg::*;
  logic        valid;
  logic        ready;
  cmd_t        cmd;
  logic [31:0] key;
  logic [31:0] key_hash;

  modport source (output valid, cmd, key, key_hash, input ready);
  modport sink (input valid, cmd, key, key_hash, output ready);
endinterface

interface ohs_rsp_if;
  import ohs_pkg::*;
  logic              valid;
  logic              ready;
  logic              found;
  logic [SLOT_W-1:0] slot;
  logic              status;
  logic [CNT_W-1:0]  entries_used;
  logic [CNT_W-1:0]  tombstones_held;

  modport source (output valid, found, slot, status, entries_used, tombstones_held,
                  input ready);
  modport sink (input valid, found, slot, status, entries_used, tombstones_held,
                output ready);
endinterface

@@ design/ohs_ctrl.sv @@
// Controller state machine of the hash set: sequences probe, sweep and
// output handshake. Depends on ohs_pkg.
module ohs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output ohs_pkg::dp_cmd_t dp_cmd,
  input  ohs_pkg::dp_sts_t dp_sts
);
  import ohs_pkg::*;

  state_t state, state_next;
  logic   clr_report, clr_report_next;
  logic   out_free;

  assign out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      clr_report <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      clr_report <= clr_report_next;
      if (dp_cmd.fin_probe || dp_cmd.fin_clear) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next      = state;
    clr_report_next = clr_report;
    dp_cmd          = '0;
    req_ready       = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (dp_sts.req_clear) begin
            dp_cmd.clr_start = 1'b1;
            clr_report_next  = 1'b1;
            state_next       = ST_SWEEP;
          end else begin
            dp_cmd.load = 1'b1;
            state_next  = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        if (!dp_sts.probe_end) begin
          dp_cmd.advance = 1'b1;
        end else if (out_free) begin
          dp_cmd.fin_probe = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        dp_cmd.sweep = 1'b1;
        if (dp_sts.sweep_done) begin
          if (!clr_report) begin
            state_next = ST_IDLE;
          end else if (out_free) begin
            dp_cmd.fin_clear = 1'b1;
            clr_report_next  = 1'b0;
            state_next       = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_SWEEP;
      end
    endcase
  end

endmodule

@@ design/ohs_dp.sv @@
// Datapath of the hash set: key and mark memories, probe position, counts
// and the output word register. Depends on ohs_pkg.
module ohs_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  ohs_pkg::dp_cmd_t          dp_cmd,
  output ohs_pkg::dp_sts_t          dp_sts,
  input  ohs_pkg::cmd_t             req_cmd,
  input  logic [31:0]               req_key,
  input  logic [31:0]               req_key_hash,
  output logic                      found,
  output logic [ohs_pkg::SLOT_W-1:0] slot,
  output logic                      status,
  output logic [ohs_pkg::CNT_W-1:0] entries_used,
  output logic [ohs_pkg::CNT_W-1:0] tombstones_held
);
  import ohs_pkg::*;

  mark_t              marks [CAPACITY];
  logic [STORE_W-1:0] keys  [CAPACITY];

  cmd_t               cmd_r;
  logic [STORE_W-1:0] key_r, key_rd;
  mark_t              mark_rd, wr_mark;
  logic [SLOT_W-1:0]  pos, tomb, sweep_cnt, rd_addr, wr_addr, fin_slot, tomb_eff;
  logic [CNT_W-1:0]   step, occ, tmb, occ_next, tmb_next;
  logic [LOAD_W-1:0]  load_sum, load_x3;
  logic               have_tomb, have_eff, hit, last, over;
  logic               add_commit, rm_commit, refuse, mark_we, key_we;

  // Probe evaluation on the slot read last cycle
  assign hit      = (mark_rd == MARK_OCCUPIED) && (key_rd == key_r);
  assign last     = (step == CNT_W'(CAPACITY));
  assign have_eff = have_tomb || (mark_rd == MARK_DELETED);
  assign tomb_eff = have_tomb ? tomb : pos;
  assign fin_slot = (!hit && have_eff) ? tomb_eff : pos;

  // Load limit: (occupied + deleted + 1) * 3 >= 2 * capacity
  assign load_sum = LOAD_W'(occ) + LOAD_W'(tmb) + LOAD_W'(1);
  assign load_x3  = (load_sum << 1) + load_sum;
  assign over     = (load_x3 >= LOAD_W'(2 * CAPACITY));

  assign add_commit = (cmd_r == CMD_ADD) && !hit && !over;
  assign refuse     = (cmd_r == CMD_ADD) && !hit && over;
  assign rm_commit  = (cmd_r == CMD_REMOVE) && hit;

  assign dp_sts.req_clear  = (req_cmd == CMD_CLEAR);
  assign dp_sts.probe_end  = (mark_rd == MARK_EMPTY) || hit || last;
  assign dp_sts.sweep_done = (sweep_cnt == SLOT_W'(CAPACITY - 1));

  always_comb begin
    occ_next = occ;
    tmb_next = tmb;
    if (add_commit) begin
      occ_next = occ + CNT_W'(1);
      if (have_eff && (tmb != '0)) begin
        tmb_next = tmb - CNT_W'(1);
      end
    end else if (rm_commit) begin
      tmb_next = tmb + CNT_W'(1);
      if (occ != '0) begin
        occ_next = occ - CNT_W'(1);
      end
    end
  end

  always_comb begin
    if (dp_cmd.load) begin
      rd_addr = req_key_hash[SLOT_W-1:0];
    end else if (dp_cmd.advance) begin
      rd_addr = pos + step[SLOT_W-1:0];
    end else begin
      rd_addr = pos;
    end
  end

  assign mark_we = dp_cmd.sweep || (dp_cmd.fin_probe && (add_commit || rm_commit));
  assign key_we  = dp_cmd.fin_probe && add_commit;
  assign wr_addr = dp_cmd.sweep ? sweep_cnt : fin_slot;
  assign wr_mark = dp_cmd.sweep ? MARK_EMPTY : (add_commit ? MARK_OCCUPIED : MARK_DELETED);

  // Memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mark_we) begin
      marks[wr_addr] <= wr_mark;
    end
    if (key_we) begin
      keys[wr_addr] <= key_r;
    end
    mark_rd <= marks[rd_addr];
    key_rd  <= keys[rd_addr];
  end

  // Control state: sweep counter and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
      occ       <= '0;
      tmb       <= '0;
    end else begin
      if (dp_cmd.clr_start) begin
        sweep_cnt <= '0;
        occ       <= '0;
        tmb       <= '0;
      end else begin
        if (dp_cmd.sweep && !dp_sts.sweep_done) begin
          sweep_cnt <= sweep_cnt + SLOT_W'(1);
        end
        if (dp_cmd.fin_probe) begin
          occ <= occ_next;
          tmb <= tmb_next;
        end
      end
    end
  end

  // Probe registers
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_r     <= req_cmd;
      key_r     <= req_key[STORE_W-1:0];
      pos       <= req_key_hash[SLOT_W-1:0];
      step      <= CNT_W'(1);
      have_tomb <= 1'b0;
    end else if (dp_cmd.advance) begin
      pos  <= rd_addr;
      step <= step + CNT_W'(1);
      if (!have_tomb && (mark_rd == MARK_DELETED)) begin
        have_tomb <= 1'b1;
        tomb      <= pos;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (dp_cmd.fin_probe) begin
      found           <= hit;
      slot            <= fin_slot;
      status          <= refuse;
      entries_used    <= occ_next;
      tombstones_held <= tmb_next;
    end else if (dp_cmd.fin_clear) begin
      found           <= 1'b0;
      slot            <= '0;
      status          <= 1'b0;
      entries_used    <= '0;
      tombstones_held <= '0;
    end
  end

endmodule

@@ design/open_addressing_hash_set.sv @@
// Top level of the open-addressing hash set: controller plus datapath.
// Depends on ohs_pkg, ohs_if, ohs_ctrl and ohs_dp.
//
// Usage:
//   req carries one word per request: cmd (add, remove, query, clear), key
//   and the requester's key_hash. rsp returns exactly one word per request:
//   found, slot, status (1 = add refused at load limit), entries_used and
//   tombstones_held after the request.
// Probe and sweep:
//   add/remove/query raise rsp.valid once the probe ends on an empty slot,
//   a match or the last probe position; the mark and key memories give one
//   registered read a cycle, and the probed slots are read one after
//   another. req.ready stays low for the whole probe, so a new request is
//   taken only once the response word of the last one is loaded. A clear
//   sweeps the mark memory one slot per cycle, keeps req.ready low while it
//   sweeps and answers once the last slot is written.
// Reset:
//   rst is synchronous, active high. After reset the block sweeps all
//   CAPACITY marks to empty with req.ready low, and emits no response
//   word for that pass.
// Stall:
//   the response word sits in an output register; a new request is taken
//   while it waits, and the next probe holds on its final slot until the
//   receiver takes the pending word.
module open_addressing_hash_set (
  input logic   clk,
  input logic   rst,
  ohs_req_if.sink   req,
  ohs_rsp_if.source rsp
);
  import ohs_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // Sequence the request: accept, probe or sweep, deliver
  ohs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .dp_cmd    (dp_cmd),
    .dp_sts    (dp_sts)
  );

  // Hold table state, evaluate probe slots and drive the response payload
  ohs_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .dp_cmd          (dp_cmd),
    .dp_sts          (dp_sts),
    .req_cmd         (req.cmd),
    .req_key         (req.key),
    .req_key_hash    (req.key_hash),
    .found           (rsp.found),
    .slot            (rsp.slot),
    .status          (rsp.status),
    .entries_used    (rsp.entries_used),
    .tombstones_held (rsp.tombstones_held)
  );

endmodule

@@ dv/open_addressing_hash_set_tb.sv @@
// Self-checking testbench for open_addressing_hash_set: drives request words,
// predicts every response word with a shadow copy of the table and compares.
// Depends on ohs_pkg, ohs_if and the design sources.
module open_addressing_hash_set_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ohs_pkg::*;

  localparam int CLK_PERIOD       = 12;
  localparam int RANDOM_ITEMS     = 1850;
  localparam int QUIET_ITEMS      = 150;   // tail of the run with no idling
  localparam int FILL_EPOCH_ITEMS = 1000;
  localparam int FILL_ITEMS       = 850;   // new-key phase of the fill epoch
  localparam int MIXED_EPOCH_ITEMS = 150;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int MAX_PRINTED      = 200;

  // one response word as the block should return it
  typedef struct packed {
    logic             found;
    logic [SLOT_W-1:0] slot;
    logic             status;
    logic [CNT_W-1:0] used;
    logic [CNT_W-1:0] tombs;
  } rsp_word_t;

  // Shadow copy of the hash set. note_request applies an accepted request
  // and queues the response word it must produce; check_response compares
  // each returned word against the oldest queued one.
  class shadow_hash_set;
    logic [31:0] stored_keys [CAPACITY];
    mark_t       marks [CAPACITY];
    int unsigned used_cnt;
    int unsigned tomb_cnt;
    rsp_word_t   awaited_responses [$];
    int unsigned mismatches;

    function new();
      foreach (marks[i]) begin
        marks[i] = MARK_EMPTY;
        stored_keys[i] = '0;
      end
      used_cnt = 0;
      tomb_cnt = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return awaited_responses.size();
    endfunction

    // Walk the triangular probe sequence; stop on an empty slot or a match.
    // A miss lands on the first tombstone passed, else on the empty slot.
    function logic [SLOT_W-1:0] probe_slot(logic [31:0] key, logic [31:0] key_hash,
                                           output logic hit);
      logic [SLOT_W-1:0] pos;
      logic [SLOT_W-1:0] stride;
      logic [SLOT_W-1:0] tomb;
      logic              have_tomb;
      pos = key_hash[SLOT_W-1:0];
      stride = 1;
      tomb = '0;
      have_tomb = 1'b0;
      hit = 1'b0;
      for (int n = 0; n < CAPACITY; n++) begin
        if (marks[pos] == MARK_EMPTY)
          return have_tomb ? tomb : pos;
        if (marks[pos] == MARK_DELETED) begin
          if (!have_tomb) begin
            have_tomb = 1'b1;
            tomb = pos;
          end
        end else if (marks[pos] == MARK_OCCUPIED && stored_keys[pos] == key) begin
          hit = 1'b1;
          return pos;
        end
        if (n + 1 < CAPACITY) begin
          pos = pos + stride;
          stride = stride + SLOT_W'(1);
        end
      end
      return have_tomb ? tomb : pos;
    endfunction

    function void note_request(cmd_t cmd, logic [31:0] key, logic [31:0] key_hash);
      rsp_word_t         w;
      logic              hit;
      logic [SLOT_W-1:0] pos;
      logic [31:0]       key_bits;
      w = '0;
      key_bits = '1;
      if (KEY_WIDTH < 32) key_bits = (32'd1 << KEY_WIDTH) - 32'd1;
      if (cmd == CMD_CLEAR) begin
        foreach (marks[i]) marks[i] = MARK_EMPTY;
        used_cnt = 0;
        tomb_cnt = 0;
      end else begin
        pos = probe_slot(key & key_bits, key_hash, hit);
        w.found = hit;
        w.slot = pos;
        if (cmd == CMD_ADD && !hit) begin
          if ((used_cnt + tomb_cnt + 1) * 3 >= CAPACITY * 2) begin
            w.status = 1'b1;
          end else begin
            if (marks[pos] == MARK_DELETED && tomb_cnt > 0) tomb_cnt--;
            stored_keys[pos] = key & key_bits;
            marks[pos] = MARK_OCCUPIED;
            used_cnt++;
          end
        end else if (cmd == CMD_REMOVE && hit) begin
          marks[pos] = MARK_DELETED;
          tomb_cnt++;
          if (used_cnt > 0) used_cnt--;
        end
      end
      w.used = used_cnt[CNT_W-1:0];
      w.tombs = tomb_cnt[CNT_W-1:0];
      awaited_responses.push_back(w);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
        $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
    endtask

    task check_response(logic found, logic [SLOT_W-1:0] slot, logic status,
                        logic [CNT_W-1:0] used, logic [CNT_W-1:0] tombs);
      rsp_word_t want;
      if (awaited_responses.size() == 0) begin
        report("response word with no request waiting", {31'd0, found}, 32'd0);
        return;
      end
      want = awaited_responses.pop_front();
      if (found !== want.found) report("found", 32'(found), 32'(want.found));
      if (slot !== want.slot) report("slot", 32'(slot), 32'(want.slot));
      if (status !== want.status) report("status", 32'(status), 32'(want.status));
      if (used !== want.used) report("entries_used", 32'(used), 32'(want.used));
      if (tombs !== want.tombs) report("tombstones_held", 32'(tombs), 32'(want.tombs));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  ohs_req_if req_ch ();
  ohs_rsp_if rsp_ch ();

  open_addressing_hash_set i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  shadow_hash_set shadow;

  // pacing controls shared by the request and response sides
  bit          idle_on;          // random idle bursts allowed in this epoch
  bit          quiet;            // tail of the run: no idling at all
  int unsigned holds_requested;  // long response hold-offs asked for so far
  int unsigned random_sent;
  logic [31:0] salt;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mix a key into a hash; keep masks the slot bits to force clustering.
  function automatic logic [31:0] hash_of(logic [31:0] key, logic [31:0] keep);
    logic [31:0] mix;
    mix = key * 32'h85EB_CA6B;
    mix = mix ^ (mix >> 13);
    mix = mix * 32'hC2B2_AE35;
    mix = mix ^ (mix >> 16);
    return mix & keep;
  endfunction

  function automatic logic [31:0] key_of(int idx);
    return salt + idx * 32'h9E37_79B9;
  endfunction

  // Offer one request word and hold it until the block takes it. Leave valid
  // high afterward: the next call either replaces the word or drops valid.
  task automatic send_request(cmd_t cmd, logic [31:0] key, logic [31:0] key_hash);
    int gap;
    gap = 0;
    if (idle_on && !quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.cmd      <= cmd;
    req_ch.key      <= key;
    req_ch.key_hash <= key_hash;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    shadow.note_request(cmd, key, key_hash);
  endtask

  task automatic send_counted(cmd_t cmd, logic [31:0] key, logic [31:0] key_hash);
    random_sent++;
    quiet = (random_sent >= RANDOM_ITEMS - QUIET_ITEMS);
    send_request(cmd, key, key_hash);
  endtask

  // Drop valid and hold off until every awaited response word is back.
  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  // One epoch of random traffic, closed by a clear. A fill epoch adds new
  // keys until the load limit refuses them, then churns the near-full table
  // so tombstones get reused. A mixed epoch works a small key pool, which
  // makes hits, repeated adds and tombstone reuse frequent.
  task automatic run_epoch(bit fill_kind, int len);
    int          next_idx;
    int          pool;
    int          idx;
    int          r;
    cmd_t        c;
    logic [31:0] k;
    logic [31:0] h;
    logic [31:0] keep;
    salt = $urandom;
    idle_on = ($urandom_range(0, 3) != 0);
    pool = $urandom_range(8, 48);
    next_idx = 0;
    case ($urandom_range(0, fill_kind ? 1 : 2))
      0: keep = '1;
      1: keep = 32'hFFFF_FC1F;  // 32 probe starts
      default: keep = 32'hFFFF_FC03;  // 4 probe starts: long chains
    endcase
    for (int j = 0; j < len && random_sent < RANDOM_ITEMS; j++) begin
      // stall the receiver for a long stretch while requests keep coming
      if (j == len / 3 && !quiet && (fill_kind || $urandom_range(0, 1) == 0))
        holds_requested++;
      r = $urandom_range(0, 99);
      if (r >= 95) begin
        // noise: any operation but clear, unrelated key and hash
        c = cmd_t'($urandom_range(0, 2));
        k = $urandom;
        h = $urandom;
      end else begin
        if (fill_kind && j < FILL_ITEMS) begin
          if (r < 85) begin
            c = CMD_ADD;
            idx = next_idx;
            next_idx++;
          end else begin
            c = (r < 90) ? CMD_REMOVE : CMD_QUERY;
            idx = $urandom_range(0, next_idx);
          end
        end else begin
          if (fill_kind) idx = $urandom_range(0, next_idx + 16);
          else idx = $urandom_range(0, pool - 1);
          if (r < 38) c = CMD_ADD;
          else if (r < 70) c = CMD_REMOVE;
          else c = CMD_QUERY;
        end
        k = key_of(idx);
        h = hash_of(k, keep);
      end
      send_counted(c, k, h);
    end
    send_counted(CMD_CLEAR, $urandom, $urandom);
  endtask

  // Response side: random ready bursts, plus the long hold-offs asked for by
  // the stimulus, counted here in cycles.
  initial begin : rsp_pacing
    int          stall;
    int unsigned holds_done;
    stall = 0;
    holds_done = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_requested > holds_done) begin
        rsp_ch.ready <= 1'b0;
        for (int held = 0; held < LONG_HOLD_CYCLES; held++) @(posedge clk);
        holds_done++;
        stall = 0;
      end else if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        stall--;
      end else if (idle_on && !quiet && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        stall = $urandom_range(1, 16) - 1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Check every response word taken by the receiver.
  always @(posedge clk) begin
    if (rst === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
      shadow.check_response(rsp_ch.found, rsp_ch.slot, rsp_ch.status,
                            rsp_ch.entries_used, rsp_ch.tombstones_held);
  end

  initial begin
    shadow = new();
    idle_on = 1'b1;
    quiet = 1'b0;
    holds_requested = 0;
    random_sent = 0;
    salt = '0;
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.cmd      <= CMD_QUERY;
    req_ch.key      <= '0;
    req_ch.key_hash <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part; the block first sweeps its marks with ready low.
    send_request(CMD_QUERY,  32'h0000_0000, 32'h0000_0000);  // miss on empty table
    send_request(CMD_ADD,    32'h0000_0000, 32'h0000_0000);
    send_request(CMD_ADD,    32'h0000_0000, 32'h0000_0000);  // add of a present key
    send_request(CMD_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF);  // top slot
    send_request(CMD_ADD,    32'h1234_5678, 32'h0000_0000);  // collides at slot 0
    send_request(CMD_ADD,    32'h0000_0005, 32'h0000_0400);  // hash wraps to 0: third probe
    send_request(CMD_QUERY,  32'h0000_0005, 32'h0000_0400);
    send_request(CMD_REMOVE, 32'h1234_5678, 32'h0000_0000);  // leaves a tombstone
    send_request(CMD_QUERY,  32'h1234_5678, 32'h0000_0000);  // miss points at tombstone
    send_request(CMD_ADD,    32'h0000_004D, 32'h0000_0000);  // reuses the tombstone
    send_request(CMD_REMOVE, 32'h0000_03E7, 32'h0000_0007);  // remove of an absent key
    send_request(CMD_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // second remove misses
    send_request(CMD_ADD,    32'h5555_5555, 32'hAAAA_AAAA);
    send_request(CMD_QUERY,  32'hAAAA_AAAA, 32'h5555_5555);
    send_request(CMD_ADD,    32'hAAAA_AAAA, 32'hFFFF_FC00);  // same start as key 0
    send_request(CMD_QUERY,  32'h5555_5555, 32'h0000_02AA);  // different hash, same slot
    send_request(CMD_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_QUERY,  32'h0000_0000, 32'h0000_0000);  // gone after clear
    send_request(CMD_ADD,    32'h0000_0000, 32'h0000_0000);
    send_request(CMD_CLEAR,  32'h0000_0000, 32'h0000_0000);

    // Random part: one fill epoch to the load limit, then mixed epochs.
    // Drain between epochs so the sender also pauses on an empty pipe;
    // keep the tail of the run back to back.
    drain_responses();
    run_epoch(1'b1, FILL_EPOCH_ITEMS);
    while (random_sent < RANDOM_ITEMS) begin
      if (!quiet) drain_responses();
      run_epoch(1'b0, MIXED_EPOCH_ITEMS);
    end

    req_ch.valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
    // catch stray words: allow a full clear sweep
    repeat (CAPACITY + 64) @(posedge clk);
    if (shadow.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: 100 ms, several times the slowest legal run.
  initial begin
    #100_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
